### hw/rtl/jsu_pkg.sv
// Shared types for the JSON string unescaper: result kinds, one result
// and the group of results that one text byte causes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  localparam int unsigned MaxRes = 4;
  localparam int unsigned CntW   = 3;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_NOTSTR = 2'd2,
    KIND_TRUNC  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] res;
    logic [CntW-1:0]   cnt;
  } batch_t;

endpackage

`default_nettype wire

### hw/rtl/jsu_decode.sv
// Parser state and single-pass decode of one text byte into up to four
// results (escape handling, hex collection, UTF-8 encoding). Uses jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            adv_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            eot_i,
  output jsu_pkg::batch_t      batch_o
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX0 = 3'd3,
    PH_HEX1 = 3'd4,
    PH_HEX2 = 3'd5,
    PH_HEX3 = 3'd6,
    PH_DONE = 3'd7
  } phase_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChBs = 8'h08;
  localparam logic [7:0] ChFf = 8'h0C;
  localparam logic [7:0] ChU = 8'h75;
  localparam logic [7:0] ChN = 8'h6E;
  localparam logic [7:0] ChR = 8'h72;
  localparam logic [7:0] ChT = 8'h74;
  localparam logic [7:0] ChB = 8'h62;
  localparam logic [7:0] ChF = 8'h66;
  localparam logic [7:0] Lead2 = 8'hC0;
  localparam logic [7:0] Lead3 = 8'hE0;
  localparam logic [7:0] Cont = 8'h80;
  localparam logic [15:0] Lim1 = 16'h0080;
  localparam logic [15:0] Lim2 = 16'h0800;

  phase_e      phase_q, phase_d;
  logic [15:0] code_q, code_d;
  logic        hex_end_q, hex_end_d;

  logic [15:0]     code_n;
  logic [3:0]      dval;
  logic            dok;
  logic [7:0]      u8 [3];
  logic [1:0]      u8_n;
  logic [7:0]      body [3];
  logic [1:0]      nbody;
  logic            term;
  kind_e           term_kind;
  logic [CntW-1:0] cnt;

  // hex digit value
  always_comb begin
    dok  = 1'b1;
    dval = 4'd0;
    if (byte_i >= "0" && byte_i <= "9") begin
      dval = 4'(byte_i - 8'h30);
    end else if (byte_i >= "a" && byte_i <= "f") begin
      dval = 4'(byte_i - 8'h57);
    end else if (byte_i >= "A" && byte_i <= "F") begin
      dval = 4'(byte_i - 8'h37);
    end else begin
      dok = 1'b0;
    end
  end

  assign code_n = (!hex_end_q && dok) ? {code_q[11:0], dval} : code_q;

  // utf-8 encoding of the collected code
  always_comb begin
    u8[0] = 8'h00;
    u8[1] = 8'h00;
    u8[2] = 8'h00;
    if (code_n < Lim1) begin
      u8_n  = 2'd1;
      u8[0] = code_n[7:0];
    end else if (code_n < Lim2) begin
      u8_n  = 2'd2;
      u8[0] = Lead2 | {3'b000, code_n[10:6]};
      u8[1] = Cont | {2'b00, code_n[5:0]};
    end else begin
      u8_n  = 2'd3;
      u8[0] = Lead3 | {4'b0000, code_n[15:12]};
      u8[1] = Cont | {2'b00, code_n[11:6]};
      u8[2] = Cont | {2'b00, code_n[5:0]};
    end
  end

  always_comb begin
    phase_d   = phase_q;
    code_d    = code_q;
    hex_end_d = hex_end_q;
    body[0]   = 8'h00;
    body[1]   = 8'h00;
    body[2]   = 8'h00;
    nbody     = 2'd0;
    term      = 1'b0;
    term_kind = KIND_DONE;
    unique case (phase_q) inside
      PH_WAIT: begin
        if (byte_i == ChSpace || (byte_i >= ChTab && byte_i <= ChCr)) begin
          if (eot_i) begin
            term      = 1'b1;
            term_kind = KIND_NOTSTR;
          end
        end else if (byte_i == ChQuote) begin
          if (eot_i) begin
            term      = 1'b1;
            term_kind = KIND_TRUNC;
          end else begin
            phase_d = PH_STR;
          end
        end else begin
          term      = 1'b1;
          term_kind = KIND_NOTSTR;
          phase_d   = eot_i ? PH_WAIT : PH_DONE;
        end
      end
      PH_STR: begin
        if (byte_i == ChQuote) begin
          term      = 1'b1;
          term_kind = KIND_DONE;
          phase_d   = eot_i ? PH_WAIT : PH_DONE;
        end else if (byte_i == ChBslash && !eot_i) begin
          phase_d = PH_ESC;
        end else begin
          body[0] = byte_i;
          nbody   = 2'd1;
          if (eot_i) begin
            term      = 1'b1;
            term_kind = KIND_TRUNC;
            phase_d   = PH_WAIT;
          end
        end
      end
      PH_ESC: begin
        if (byte_i == ChU) begin
          code_d    = 16'h0000;
          hex_end_d = 1'b0;
          if (eot_i) begin
            term      = 1'b1;
            term_kind = KIND_TRUNC;
            phase_d   = PH_WAIT;
          end else begin
            phase_d = PH_HEX0;
          end
        end else begin
          nbody = 2'd1;
          case (byte_i)
            ChN:     body[0] = ChLf;
            ChR:     body[0] = ChCr;
            ChT:     body[0] = ChTab;
            ChB:     body[0] = ChBs;
            ChF:     body[0] = ChFf;
            default: body[0] = byte_i;
          endcase
          phase_d = PH_STR;
          if (eot_i) begin
            term      = 1'b1;
            term_kind = KIND_TRUNC;
            phase_d   = PH_WAIT;
          end
        end
      end
      PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
        code_d    = code_n;
        hex_end_d = hex_end_q | !dok;
        if (phase_q == PH_HEX3) begin
          body    = u8;
          nbody   = u8_n;
          phase_d = PH_STR;
          if (eot_i) begin
            term      = 1'b1;
            term_kind = KIND_TRUNC;
            phase_d   = PH_WAIT;
          end
        end else if (eot_i) begin
          term      = 1'b1;
          term_kind = KIND_TRUNC;
          phase_d   = PH_WAIT;
        end else if (phase_q == PH_HEX0) begin
          phase_d = PH_HEX1;
        end else if (phase_q == PH_HEX1) begin
          phase_d = PH_HEX2;
        end else begin
          phase_d = PH_HEX3;
        end
      end
      PH_DONE: begin
        if (eot_i) begin
          phase_d = PH_WAIT;
        end
      end
      default: begin
        phase_d = PH_WAIT;
      end
    endcase
  end

  // pack body bytes then the optional terminal result
  assign cnt = {1'b0, nbody} + {2'b00, term};

  always_comb begin
    batch_o.cnt = cnt;
    for (int i = 0; i < MaxRes; i++) begin
      if (CntW'(i) < {1'b0, nbody}) begin
        batch_o.res[i].data = body[i % 3];
        batch_o.res[i].kind = KIND_BYTE;
      end else begin
        batch_o.res[i].data = 8'h00;
        batch_o.res[i].kind = term_kind;
      end
      batch_o.res[i].last = (CntW'(i + 1) == cnt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT;
      code_q    <= 16'h0000;
      hex_end_q <= 1'b0;
    end else if (adv_i) begin
      phase_q   <= phase_d;
      code_q    <= code_d;
      hex_end_q <= hex_end_d;
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt <= CntW'(MaxRes))
    else $error("more results than the queue holds");

endmodule

`default_nettype wire

### hw/rtl/jsu_outbuf.sv
// Result queue: holds the results of one byte and drains them one per
// cycle on the output stream while the receiver is ready. Uses jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_outbuf (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   load_i,
  input  wire jsu_pkg::batch_t batch_i,
  output logic        can_load_o,
  output logic        valid_o,
  input  wire logic   ready_i,
  output jsu_pkg::res_t head_o
);
  import jsu_pkg::*;

  res_t [MaxRes-1:0] ent_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;

  assign valid_o    = (cnt_q != '0);
  assign pop        = valid_o && ready_i;
  assign can_load_o = (cnt_q == '0) || (cnt_q == CntW'(1) && pop);
  assign head_o     = ent_q[0];

  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = batch_i.cnt;
    end else if (pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= batch_i.res;
    end else if (pop) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        ent_q[i] <= ent_q[i + 1];
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> can_load_o)
    else $error("results loaded over undelivered results");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head_o.last) |=> (cnt_q == '0 || $past(load_i)))
    else $error("results left after the last one of a byte");

endmodule

`default_nettype wire

### hw/rtl/json_string_unescape_utf8.sv
// JSON string unescaper, top level: input register, decode stage and
// result queue. Depends on jsu_pkg, jsu_decode and jsu_outbuf.
`timescale 1ns / 1ps
`default_nettype none

// Takes JSON text one byte per request starting at a value position, skips
// leading whitespace, requires an opening quote and streams out the decoded
// string bytes, with \u escapes turned into one to three UTF-8 bytes, then a
// status result (string complete, not a string, or truncated). Bytes with at
// most one result go through back to back while the output is ready; a byte
// with more (up to four: three UTF-8 bytes and a truncation) holds up the next
// byte until its last result is taken, since the single output port drains
// the result queue one result per cycle while the receiver is ready. A byte
// passes the input register, then the result queue. After a status the block
// drops bytes up to the one marked tlast, then waits for the next text.
module json_string_unescape_utf8 (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // [7:0] text_byte
  input  wire logic       s_axis_tlast,  // end_of_text
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,  // [7:0] decoded_byte
  output logic [1:0]      m_axis_tuser,  // [1:0] kind
  output logic            m_axis_tlast   // run_last
);
  import jsu_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_eot_q;
  logic       accept;
  logic       proc;
  logic       can_load;
  batch_t     batch;
  res_t       head;

  assign proc          = in_vld_q && can_load;
  assign s_axis_tready = !in_vld_q || proc;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_vld_d      = accept || (in_vld_q && !proc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= s_axis_tdata;
      in_eot_q  <= s_axis_tlast;
    end
  end

  jsu_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (proc),
    .byte_i  (in_byte_q),
    .eot_i   (in_eot_q),
    .batch_o (batch)
  );

  jsu_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (proc),
    .batch_i    (batch),
    .can_load_o (can_load),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .head_o     (head)
  );

  assign m_axis_tdata = head.data;
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> s_axis_tready)
    else $error("input stalled with an empty input register");

  a_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !proc) |=> (in_vld_q && $stable(in_byte_q) && $stable(in_eot_q)))
    else $error("pending request lost or changed");

endmodule

`default_nettype wire

### sim/json_string_unescape_utf8_test.sv
// Testbench for json_string_unescape_utf8: sends JSON text, predicts the decoded
// bytes and status results, and checks each result at the output.
// Depends on jsu_pkg and the json_string_unescape_utf8 RTL.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8_test;
  import jsu_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [7:0] QUOTE  = 8'h22;
  localparam logic [7:0] BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    TXT_WAIT = 3'd0,
    TXT_STR  = 3'd1,
    TXT_ESC  = 3'd2,
    TXT_HEX1 = 3'd3,
    TXT_HEX2 = 3'd4,
    TXT_HEX3 = 3'd5,
    TXT_HEX4 = 3'd6,
    TXT_SKIP = 3'd7
  } text_phase_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b1;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  text_phase_e txt_phase = TXT_WAIT;
  logic [15:0] code_acc = 16'h0000;
  logic        hex_stop = 1'b0;

  res_t       step_q[$];
  res_t       pending_results[$];
  logic [7:0] text_buf[$];

  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned ready_cycle = 0;
  int          burst_left = 0;
  int          bytes_sent = 0;

  json_string_unescape_utf8 u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stalls: full rate, coin flip, mostly stalled, regular gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b1;
    end else begin
      ready_cycle++;
      case ((ready_cycle / 97) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom % 2) == 0;
        2: m_axis_tready <= $urandom_range(0, 3) == 0;
        default: m_axis_tready <= (ready_cycle % 5) != 0;
      endcase
    end
  end

  function automatic void add_result(input kind_e k, input logic [7:0] val);
    res_t r;
    r.data = (k == KIND_BYTE) ? val : 8'h00;
    r.kind = k;
    r.last = 1'b0;
    step_q.insert(step_q.size(), r);
  endfunction

  function automatic void end_text(input kind_e k, input logic eot);
    add_result(k, 8'h00);
    txt_phase = eot ? TXT_WAIT : TXT_SKIP;
  endfunction

  function automatic void add_utf8(input logic [15:0] code);
    if (code < 16'h0080) begin
      add_result(KIND_BYTE, code[7:0]);
    end else if (code < 16'h0800) begin
      add_result(KIND_BYTE, 8'hC0 | 8'(code >> 6));
      add_result(KIND_BYTE, 8'h80 | {2'b00, code[5:0]});
    end else begin
      add_result(KIND_BYTE, 8'hE0 | 8'(code >> 12));
      add_result(KIND_BYTE, 8'h80 | {2'b00, code[11:6]});
      add_result(KIND_BYTE, 8'h80 | {2'b00, code[5:0]});
    end
  endfunction

  function automatic void predict_unescape(input logic [7:0] c, input logic eot);
    int digit;
    step_q.delete();
    case (txt_phase)
      TXT_WAIT: begin
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
          if (eot) end_text(KIND_NOTSTR, 1'b1);
        end else if (c == QUOTE) begin
          if (eot) end_text(KIND_TRUNC, 1'b1);
          else txt_phase = TXT_STR;
        end else begin
          end_text(KIND_NOTSTR, eot);
        end
      end
      TXT_STR: begin
        if (c == QUOTE) begin
          end_text(KIND_DONE, eot);
        end else if (c == BSLASH && !eot) begin
          txt_phase = TXT_ESC;
        end else begin
          add_result(KIND_BYTE, c);
          if (eot) end_text(KIND_TRUNC, 1'b1);
        end
      end
      TXT_ESC: begin
        if (c == "u") begin
          code_acc = 16'h0000;
          hex_stop = 1'b0;
          if (eot) end_text(KIND_TRUNC, 1'b1);
          else txt_phase = TXT_HEX1;
        end else begin
          case (c)
            "n": add_result(KIND_BYTE, 8'h0A);
            "r": add_result(KIND_BYTE, 8'h0D);
            "t": add_result(KIND_BYTE, 8'h09);
            "b": add_result(KIND_BYTE, 8'h08);
            "f": add_result(KIND_BYTE, 8'h0C);
            default: add_result(KIND_BYTE, c);
          endcase
          txt_phase = TXT_STR;
          if (eot) end_text(KIND_TRUNC, 1'b1);
        end
      end
      TXT_SKIP: begin
        if (eot) txt_phase = TXT_WAIT;
      end
      default: begin
        digit = -1;
        if (c >= "0" && c <= "9") digit = int'(c - "0");
        else if (c >= "a" && c <= "f") digit = c - "a" + 10;
        else if (c >= "A" && c <= "F") digit = c - "A" + 10;
        if (!hex_stop && digit >= 0) code_acc = {code_acc[11:0], 4'(digit)};
        else hex_stop = 1'b1;
        if (txt_phase == TXT_HEX4) begin
          add_utf8(code_acc);
          txt_phase = TXT_STR;
          if (eot) end_text(KIND_TRUNC, 1'b1);
        end else if (eot) begin
          end_text(KIND_TRUNC, 1'b1);
        end else begin
          txt_phase = text_phase_e'(txt_phase + 3'd1);
        end
      end
    endcase
    if (step_q.size() != 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) pending_results.insert(pending_results.size(), step_q[i]);
  endfunction

  function automatic void report_mismatch(input string what, input res_t want, input res_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t %s: expected data %h kind %0d last %b, got data %h kind %0d last %b",
               $realtime, what, want.data, want.kind, want.last, got.data, got.kind,
               got.last);
  endfunction

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.data = m_axis_tdata;
      got.kind = kind_e'(m_axis_tuser);
      got.last = m_axis_tlast;
      if (pending_results.size() == 0) begin
        want = '0;
        report_mismatch("unexpected result", want, got);
      end else begin
        want = pending_results.pop_front();
        if (got.data !== want.data || got.kind !== want.kind || got.last !== want.last)
          report_mismatch("result mismatch", want, got);
      end
    end
  end

  // one request per call; the sender runs in bursts with random gaps
  task automatic push_text_byte(input logic [7:0] c, input logic eot);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_unescape(c, eot);
    bytes_sent++;
  endtask

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.insert(text_buf.size(), s[i]);
  endfunction

  task automatic flush_text();
    for (int i = 0; i < text_buf.size(); i++)
      push_text_byte(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_whitespace_and_escapes();
    text_buf = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    put_str("\"A\\\"\\\\\\/\\n\\r\\t\\b\\f\\q\\");
    text_buf.insert(text_buf.size(), 8'hFF);
    text_buf.insert(text_buf.size(), 8'h00);
    put_str("\"tail");
    flush_text();
  endtask

  task automatic test_not_a_string();
    put_str("  ");
    flush_text();
    put_str("x12");
    flush_text();
    put_str("\"");
    flush_text();
    put_str("\"ok\"");
    flush_text();
  endtask

  task automatic test_unicode();
    put_str("\"\\u0000\\u007F\\u0080\\u07ff\\u0800\\uFFFF\\uD83D\\uaBcD\\u12G4\\uZ999\"");
    flush_text();
  endtask

  task automatic test_truncation();
    put_str("\"ab\\");
    flush_text();
    put_str("\"\\u12");
    flush_text();
    put_str("\"\\u");
    flush_text();
    put_str("\"\\u20AC");
    flush_text();
    put_str("\"\\n");
    flush_text();
    put_str("\"abc");
    flush_text();
  endtask

  task automatic test_random();
    int sent_start;
    int sel;
    int code;
    logic [7:0] c;
    logic [3:0] nib;
    bit drained_once;
    string simple_esc;
    simple_esc = "\"\\/nrtbf";
    sent_start = bytes_sent;
    drained_once = 1'b0;
    while (bytes_sent - sent_start < 120) begin
      text_buf.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) text_buf.insert(text_buf.size(), 8'($urandom));
      end else begin
        repeat ($urandom_range(0, 2)) begin
          sel = $urandom_range(0, 5);
          text_buf.insert(text_buf.size(), sel == 5 ? 8'h20 : 8'(8'h09 + sel));
        end
        text_buf.insert(text_buf.size(), QUOTE);
        repeat ($urandom_range(0, 6)) begin
          sel = $urandom_range(0, 9);
          if (sel <= 4) begin
            do c = 8'($urandom); while (c == QUOTE || c == BSLASH);
            text_buf.insert(text_buf.size(), c);
          end else if (sel <= 6) begin
            text_buf.insert(text_buf.size(), BSLASH);
            if ($urandom_range(0, 9) != 0) begin
              c = simple_esc[$urandom_range(0, simple_esc.len() - 1)];
              text_buf.insert(text_buf.size(), c);
            end else begin
              do c = 8'($urandom); while (c == "u");
              text_buf.insert(text_buf.size(), c);
            end
          end else begin
            case ($urandom_range(0, 2))
              0: code = $urandom_range(0, 16'h007F);
              1: code = $urandom_range(16'h0080, 16'h07FF);
              default: code = $urandom_range(16'h0800, 16'hFFFF);
            endcase
            text_buf.insert(text_buf.size(), BSLASH);
            text_buf.insert(text_buf.size(), "u");
            for (int k = 3; k >= 0; k--) begin
              nib = 4'(code >> (4 * k));
              if ($urandom_range(0, 9) == 0) c = 8'($urandom);
              else if (nib < 10) c = "0" + nib;
              else if ($urandom % 2) c = 8'("A" + nib - 10);
              else c = 8'("a" + nib - 10);
              text_buf.insert(text_buf.size(), c);
            end
          end
        end
        if ($urandom_range(0, 7) != 0) text_buf.insert(text_buf.size(), QUOTE);
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 2)) text_buf.insert(text_buf.size(), 8'($urandom));
        if ($urandom_range(0, 5) == 0 && text_buf.size() > 1)
          repeat ($urandom_range(1, text_buf.size() - 1)) void'(text_buf.pop_back());
      end
      flush_text();
      if (!drained_once || $urandom_range(0, 7) == 0) begin
        wait_drained();
        repeat ($urandom_range(0, 4)) @(negedge clk_i);
        drained_once = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_whitespace_and_escapes();
    test_not_a_string();
    test_unicode();
    test_truncation();
    test_random();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
